### rtl/core/ccb_pkg.sv
// ----------------------------------------------------------------------------
// ccb_pkg
// Shared widths, register indexes, destination codes and the bin result
// record for the coin classify and bin block.
// ----------------------------------------------------------------------------
package ccb_pkg;

  localparam int MAX_TYPES_DEF = 5;

  localparam int WEIGHT_W  = 16;
  localparam int DIAM_W    = 16;
  localparam int MATCH_W   = 2;
  localparam int DEST_W    = 2;
  localparam int TIDX_W    = 3;
  localparam int FILL_W    = 6;
  localparam int CNT_W     = 16;
  localparam int BINW_W    = 20;
  localparam int NTYPES_W  = 3;
  localparam int SPEC_W    = 62;
  localparam int TOL_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 62;

  localparam int SPEC_WNOM_LSB = 0;
  localparam int SPEC_WTOL_LSB = 16;
  localparam int SPEC_DNOM_LSB = 28;
  localparam int SPEC_DTOL_LSB = 44;
  localparam int SPEC_CAP_LSB  = 56;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_TYPES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BENT_CAP  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OTHER_CAP = 3'd7;

  localparam logic [NTYPES_W-1:0] NUM_TYPES_RST = 3'd1;
  localparam logic [BINW_W-1:0]   BENT_CAP_RST  = 20'd300000;
  localparam logic [BINW_W-1:0]   OTHER_CAP_RST = 20'd200000;

  localparam logic [MATCH_W-1:0] MATCH_BOTH = 2'd2;
  localparam logic [FILL_W-1:0]  FILL_MAX   = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX    = '1;

  typedef enum logic [DEST_W-1:0] {
    DEST_BENT  = 2'd0,
    DEST_ROLL  = 2'd1,
    DEST_OTHER = 2'd2
  } dest_t;

  typedef struct packed {
    logic [BINW_W-1:0] weight;
    logic              replaced;
    logic [CNT_W-1:0]  full;
    logic [CNT_W-1:0]  coins;
  } bin_res_t;

endpackage

### rtl/core/ccb_ifs.sv
// ----------------------------------------------------------------------------
// ccb_ifs
// Valid/ready channels carrying one measured coin word and one result word.
// ----------------------------------------------------------------------------
interface ccb_in_if;
  logic                          valid;
  logic                          ready;
  logic [ccb_pkg::WEIGHT_W-1:0]  weight_mg;
  logic [ccb_pkg::DIAM_W-1:0]    diameter_um;
  logic                          is_bent;
  logic [ccb_pkg::MATCH_W-1:0]   image_match;

  modport source (output valid, weight_mg, diameter_um, is_bent, image_match,
                  input ready);
  modport sink   (input valid, weight_mg, diameter_um, is_bent, image_match,
                  output ready);
endinterface

interface ccb_out_if;
  logic                          valid;
  logic                          ready;
  logic [ccb_pkg::DEST_W-1:0]    destination;
  logic [ccb_pkg::TIDX_W-1:0]    type_index;
  logic [ccb_pkg::FILL_W-1:0]    roll_fill;
  logic                          roll_full;
  logic [ccb_pkg::CNT_W-1:0]     rolls_started;
  logic [ccb_pkg::BINW_W-1:0]    container_weight_mg;
  logic                          container_replaced;
  logic [ccb_pkg::CNT_W-1:0]     containers_filled;
  logic [ccb_pkg::CNT_W-1:0]     container_coins;

  modport source (output valid, destination, type_index, roll_fill, roll_full,
                  rolls_started, container_weight_mg, container_replaced,
                  containers_filled, container_coins,
                  input ready);
  modport sink   (input valid, destination, type_index, roll_fill, roll_full,
                  rolls_started, container_weight_mg, container_replaced,
                  containers_filled, container_coins,
                  output ready);
endinterface

### rtl/core/ccb_bin.sv
// ----------------------------------------------------------------------------
// ccb_bin
// Container accumulator: running weight, coin count and full-container count,
// starting a new container when the capacity would be reached.
// ----------------------------------------------------------------------------
module ccb_bin (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [ccb_pkg::WEIGHT_W-1:0] coin_wt,
  input  logic [ccb_pkg::BINW_W-1:0]   cap,
  output ccb_pkg::bin_res_t            res
);

  logic [ccb_pkg::BINW_W-1:0] weight_r, weight_nxt;
  logic [ccb_pkg::CNT_W-1:0]  coins_r, coins_nxt;
  logic [ccb_pkg::CNT_W-1:0]  full_r, full_nxt;
  logic [ccb_pkg::BINW_W:0]   sum;
  logic                       replace;

  always_comb begin
    sum     = {1'b0, weight_r} + (ccb_pkg::BINW_W + 1)'(coin_wt);
    replace = sum >= {1'b0, cap};
    if (replace) begin
      weight_nxt = ccb_pkg::BINW_W'(coin_wt);
      coins_nxt  = ccb_pkg::CNT_W'(1);
      full_nxt   = (full_r == ccb_pkg::CNT_MAX) ? full_r : full_r + 1'b1;
    end else begin
      weight_nxt = sum[ccb_pkg::BINW_W-1:0];
      coins_nxt  = (coins_r == ccb_pkg::CNT_MAX) ? coins_r : coins_r + 1'b1;
      full_nxt   = full_r;
    end
    res.weight   = weight_nxt;
    res.replaced = replace;
    res.full     = full_nxt;
    res.coins    = coins_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
      coins_r  <= '0;
      full_r   <= '0;
    end else if (en) begin
      weight_r <= weight_nxt;
      coins_r  <= coins_nxt;
      full_r   <= full_nxt;
    end
  end

endmodule

### rtl/core/coin_classify_and_bin.sv
// ----------------------------------------------------------------------------
// coin_classify_and_bin
// Classifies each measured coin against the configured types and routes it
// to a type roll, the bent container or the other container.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word
//  in_word  in   weight_mg, diameter_um, is_bent, image_match
//  out_word out  destination, type_index, roll/container counts
//  cfg_*    in   register index, write data (no read-back)
//
//  One coin per cycle while the output is not stalled; a coin passes the input
//  register, then the result register, with the tolerance compare and counter
//  update between them. State is committed as a word moves into the result register,
//  so the next coin sees it at once. Reset clears all counters and restores
//  register defaults. A stalled result holds; input stalls only when both
//  registers are occupied.
// ----------------------------------------------------------------------------
module coin_classify_and_bin #(
  parameter int MAX_TYPES = ccb_pkg::MAX_TYPES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ccb_in_if.sink                        in_word,
  ccb_out_if.source                     out_word,
  input  logic                          cfg_we,
  input  logic [ccb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int FW = ccb_pkg::FILL_W;
  localparam int CW = ccb_pkg::CNT_W;

  // configuration
  logic [ccb_pkg::NTYPES_W-1:0] num_types_r;
  logic [ccb_pkg::SPEC_W-1:0]   spec_r [MAX_TYPES];
  logic [ccb_pkg::BINW_W-1:0]   bent_cap_r, other_cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_types_r <= ccb_pkg::NUM_TYPES_RST;
      bent_cap_r  <= ccb_pkg::BENT_CAP_RST;
      other_cap_r <= ccb_pkg::OTHER_CAP_RST;
      for (int i = 0; i < MAX_TYPES; i++) spec_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == ccb_pkg::CFG_NUM_TYPES) num_types_r <= cfg_data[2:0];
      if (cfg_index == ccb_pkg::CFG_BENT_CAP)  bent_cap_r  <= cfg_data[19:0];
      if (cfg_index == ccb_pkg::CFG_OTHER_CAP) other_cap_r <= cfg_data[19:0];
      for (int i = 0; i < MAX_TYPES; i++) begin
        if (cfg_index == ccb_pkg::CFG_IDX_W'(ccb_pkg::CFG_SPEC0 + i))
          spec_r[i] <= cfg_data[ccb_pkg::SPEC_W-1:0];
      end
    end
  end

  // handshake
  logic s1_valid_r, out_valid_r;
  logic out_adv, s1_adv;

  assign out_adv       = !out_valid_r || out_word.ready;
  assign s1_adv        = s1_valid_r && out_adv;
  assign in_word.ready = !s1_valid_r || out_adv;

  // input register
  logic [ccb_pkg::WEIGHT_W-1:0] s1_weight_r;
  logic [ccb_pkg::DIAM_W-1:0]   s1_diam_r;
  logic                         s1_bent_r;
  logic [ccb_pkg::MATCH_W-1:0]  s1_match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_word.ready) begin
      s1_valid_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.valid && in_word.ready) begin
      s1_weight_r <= in_word.weight_mg;
      s1_diam_r   <= in_word.diameter_um;
      s1_bent_r   <= in_word.is_bent;
      s1_match_r  <= in_word.image_match;
    end
  end

  // type match
  logic [MAX_TYPES-1:0]         match, hit_oh;
  logic                         hit;
  logic [ccb_pkg::TIDX_W-1:0]   hit_idx;
  logic [FW-1:0]                sel_cap, sel_fill;
  logic [CW-1:0]                sel_started;
  logic [FW-1:0]                fill_r [MAX_TYPES];
  logic [CW-1:0]                started_r [MAX_TYPES];

  always_comb begin
    logic [ccb_pkg::WEIGHT_W-1:0] wnom, wdiff;
    logic [ccb_pkg::DIAM_W-1:0]   dnom, ddiff;
    logic [ccb_pkg::TOL_W-1:0]    wtol, dtol;
    for (int i = 0; i < MAX_TYPES; i++) begin
      wnom  = spec_r[i][ccb_pkg::SPEC_WNOM_LSB +: ccb_pkg::WEIGHT_W];
      wtol  = spec_r[i][ccb_pkg::SPEC_WTOL_LSB +: ccb_pkg::TOL_W];
      dnom  = spec_r[i][ccb_pkg::SPEC_DNOM_LSB +: ccb_pkg::DIAM_W];
      dtol  = spec_r[i][ccb_pkg::SPEC_DTOL_LSB +: ccb_pkg::TOL_W];
      wdiff = (s1_weight_r >= wnom) ? s1_weight_r - wnom : wnom - s1_weight_r;
      ddiff = (s1_diam_r >= dnom) ? s1_diam_r - dnom : dnom - s1_diam_r;
      match[i] = (ccb_pkg::NTYPES_W'(i) < num_types_r) &&
                 (wdiff <= ccb_pkg::WEIGHT_W'(wtol)) &&
                 (ddiff <= ccb_pkg::DIAM_W'(dtol));
    end
    hit         = 1'b0;
    hit_oh      = '0;
    hit_idx     = '0;
    sel_cap     = '0;
    sel_fill    = '0;
    sel_started = '0;
    if (s1_match_r == ccb_pkg::MATCH_BOTH) begin
      for (int i = 0; i < MAX_TYPES; i++) begin
        if (!hit && match[i]) begin
          hit         = 1'b1;
          hit_oh[i]   = 1'b1;
          hit_idx     = ccb_pkg::TIDX_W'(i);
          sel_cap     = spec_r[i][ccb_pkg::SPEC_CAP_LSB +: FW];
          sel_fill    = fill_r[i];
          sel_started = started_r[i];
        end
      end
    end
  end

  // roll update
  logic [FW-1:0] fill_nxt;
  logic [CW-1:0] started_nxt;

  always_comb begin
    fill_nxt    = sel_fill;
    started_nxt = sel_started;
    if (sel_fill == sel_cap) begin
      fill_nxt    = FW'(1);
      started_nxt = (sel_started == ccb_pkg::CNT_MAX) ? sel_started : sel_started + 1'b1;
    end else if (sel_fill != ccb_pkg::FILL_MAX) begin
      fill_nxt = sel_fill + 1'b1;
    end
  end

  ccb_pkg::dest_t dest;
  assign dest = s1_bent_r ? ccb_pkg::DEST_BENT :
                hit       ? ccb_pkg::DEST_ROLL : ccb_pkg::DEST_OTHER;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TYPES; i++) begin
        fill_r[i]    <= '0;
        started_r[i] <= '0;
      end
    end else if (s1_adv && dest == ccb_pkg::DEST_ROLL) begin
      for (int i = 0; i < MAX_TYPES; i++) begin
        if (hit_oh[i]) begin
          fill_r[i]    <= fill_nxt;
          started_r[i] <= started_nxt;
        end
      end
    end
  end

  // containers
  ccb_pkg::bin_res_t bent_res, other_res;

  ccb_bin u_bent_bin (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_adv && dest == ccb_pkg::DEST_BENT),
    .coin_wt (s1_weight_r),
    .cap     (bent_cap_r),
    .res     (bent_res)
  );

  ccb_bin u_other_bin (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_adv && dest == ccb_pkg::DEST_OTHER),
    .coin_wt (s1_weight_r),
    .cap     (other_cap_r),
    .res     (other_res)
  );

  // result register
  ccb_pkg::dest_t             dest_r;
  logic [ccb_pkg::TIDX_W-1:0] tidx_r;
  logic [FW-1:0]              fill_out_r;
  logic                       full_out_r;
  logic [CW-1:0]              started_out_r;
  ccb_pkg::bin_res_t          bin_out_r, bin_sel;

  always_comb begin
    case (dest)
      ccb_pkg::DEST_BENT:  bin_sel = bent_res;
      ccb_pkg::DEST_OTHER: bin_sel = other_res;
      default:             bin_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      dest_r    <= dest;
      bin_out_r <= bin_sel;
      if (dest == ccb_pkg::DEST_ROLL) begin
        tidx_r        <= hit_idx;
        fill_out_r    <= fill_nxt;
        full_out_r    <= (fill_nxt == sel_cap);
        started_out_r <= started_nxt;
      end else begin
        tidx_r        <= '0;
        fill_out_r    <= '0;
        full_out_r    <= 1'b0;
        started_out_r <= '0;
      end
    end
  end

  assign out_word.valid               = out_valid_r;
  assign out_word.destination         = dest_r;
  assign out_word.type_index          = tidx_r;
  assign out_word.roll_fill           = fill_out_r;
  assign out_word.roll_full           = full_out_r;
  assign out_word.rolls_started       = started_out_r;
  assign out_word.container_weight_mg = bin_out_r.weight;
  assign out_word.container_replaced  = bin_out_r.replaced;
  assign out_word.containers_filled   = bin_out_r.full;
  assign out_word.container_coins     = bin_out_r.coins;

  // checks
  a_roll_no_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dest_r == ccb_pkg::DEST_ROLL |->
      bin_out_r == '0 && fill_out_r != '0)
    else $error("roll result carries container data or empty fill");

  a_bin_no_roll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dest_r != ccb_pkg::DEST_ROLL |->
      tidx_r == '0 && fill_out_r == '0 && !full_out_r)
    else $error("container result carries roll data");

  a_replace_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && bin_out_r.replaced |-> bin_out_r.coins == CW'(1))
    else $error("new container does not hold exactly one coin");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_adv |=> s1_valid_r && $stable(s1_weight_r))
    else $error("input register lost a word while stalled");

endmodule
